// File: rtl/astf_pkg.sv
`timescale 1ns / 1ps

package astf_pkg;

	// Field widths fixed by the command and response formats
	localparam int unsigned CMD_W    = 3;
	localparam int unsigned IDX_W    = 6;
	localparam int unsigned FRAME_W  = 8;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned TICKS_W  = 32;
	localparam int unsigned STATUS_W = 3;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SET_PER = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SET_FRM = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_ZERO_DUR  = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [IDX_W-1:0]    step_index;
		logic [FRAME_W-1:0]  frame_index;
		logic [PERIOD_W-1:0] period;
		logic [TICKS_W-1:0]  elapsed_ticks;
	} cmd_beat_t;

	typedef struct packed {
		logic [IDX_W-1:0]    found_step;
		logic [FRAME_W-1:0]  found_frame;
		logic [STATUS_W-1:0] status;
	} rsp_beat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETP,
		S_DIV,
		S_WALK,
		S_DONE
	} state_t;

endpackage

// File: rtl/animation_step_finder_top.sv
`timescale 1ns / 1ps

// Animation step table with time lookup.
// Command channel (cmd_valid / cmd_stall / cmd) takes one command a beat:
// clear, append a step, rewrite a step's period or frame, or look up a time
// in ticks. Response channel (rsp_valid / rsp_stall / rsp) returns exactly
// one beat per command, in order, with the found step, its frame and a status.
// The block works on one command at a time; cmd_stall is high from acceptance
// until the response has been loaded into the output register.
// Clear, append, set frame and rejected commands go straight to the
// response; set period first does one read of the period memory; lookup
// runs a bit-serial restoring remainder of the 32-bit elapsed ticks against
// the total duration, then a walk over the period memory at one entry a
// cycle until it reaches the step that holds the time or the last step.
// The next command is taken once the response is loaded.
// Reset empties the table (step count and total duration to zero); the
// memories need no clearing pass since entries past the count are never used.
// When the receiver stalls, the response waits in the output register and a
// finished next response waits in the block, which takes no new command.
module animation_step_finder_top #(
	parameter int unsigned MAX_STEPS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  astf_pkg::cmd_beat_t cmd,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output astf_pkg::rsp_beat_t rsp
);

	localparam int unsigned ADDR_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int unsigned CNT_W  = $clog2(MAX_STEPS + 1);
	localparam int unsigned TOT_W  = astf_pkg::PERIOD_W + ADDR_W;
	localparam int unsigned CMP_W  = (CNT_W > astf_pkg::IDX_W) ? CNT_W : astf_pkg::IDX_W;
	localparam int unsigned BIT_W  = $clog2(astf_pkg::TICKS_W);

	astf_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]               count_q;
	logic [TOT_W-1:0]               total_q;
	logic [ADDR_W-1:0]              addr_q;
	logic [ADDR_W-1:0]              cmp_idx_q;
	logic                           data_ok_q;
	logic [astf_pkg::PERIOD_W-1:0]  per_q;
	logic [TOT_W-1:0]               rem_q;
	logic [astf_pkg::TICKS_W-1:0]   quo_q;
	logic [BIT_W-1:0]               bit_q;
	astf_pkg::rsp_beat_t            res_q;
	astf_pkg::rsp_beat_t            rsp_q;
	logic                           rsp_valid_q;

	logic                           accept;
	logic                           out_free;
	logic                           full;
	logic                           idx_ok;
	logic [CMP_W-1:0]               idx_ext;
	logic [ADDR_W-1:0]              idx_addr;
	logic [ADDR_W-1:0]              cnt_addr;
	logic [astf_pkg::STATUS_W-1:0]  cmd_status;

	logic                           ram_per_we;
	logic                           ram_frm_we;
	logic [ADDR_W-1:0]              ram_addr;
	logic [astf_pkg::PERIOD_W-1:0]  ram_per_wdata;
	logic [astf_pkg::FRAME_W-1:0]   ram_frm_wdata;
	logic [astf_pkg::PERIOD_W-1:0]  per_rdata;
	logic [astf_pkg::FRAME_W-1:0]   frm_rdata;

	logic [TOT_W:0]                 trial;
	logic [TOT_W:0]                 trial_diff;
	logic [TOT_W-1:0]               rem_div;
	logic [TOT_W-1:0]               per_ext;
	logic                           hit;
	logic                           last;
	logic [CMP_W-1:0]               found_ext;

	// Handshake and command checks
	assign accept   = cmd_valid && (state_q == astf_pkg::S_IDLE);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign full     = (count_q == CNT_W'(MAX_STEPS));
	assign idx_ext  = CMP_W'(cmd.step_index);
	assign idx_ok   = (idx_ext < CMP_W'(count_q)) && (idx_ext < CMP_W'(MAX_STEPS));
	assign idx_addr = idx_ext[ADDR_W-1:0];
	assign cnt_addr = count_q[ADDR_W-1:0];

	// Status of the incoming command before any walk
	always_comb begin
		cmd_status = astf_pkg::STATUS_OK;
		case (cmd.command)
			astf_pkg::CMD_CLEAR: ;
			astf_pkg::CMD_APPEND: begin
				if (full) begin
					cmd_status = astf_pkg::STATUS_FULL;
				end
			end
			astf_pkg::CMD_SET_PER, astf_pkg::CMD_SET_FRM: begin
				if (!idx_ok) begin
					cmd_status = astf_pkg::STATUS_BAD_INDEX;
				end
			end
			astf_pkg::CMD_LOOKUP: begin
				if (count_q == '0) begin
					cmd_status = astf_pkg::STATUS_EMPTY;
				end else if (total_q == '0) begin
					cmd_status = astf_pkg::STATUS_ZERO_DUR;
				end
			end
			default: cmd_status = astf_pkg::STATUS_BAD_INDEX;
		endcase
	end

	// One remainder step: shift in the next dividend bit, subtract if it fits
	assign trial      = {rem_q, quo_q[astf_pkg::TICKS_W-1]};
	assign trial_diff = trial - {1'b0, total_q};
	assign rem_div    = (trial >= {1'b0, total_q}) ? trial_diff[TOT_W-1:0] : trial[TOT_W-1:0];

	// Walk compare on the period just read
	assign per_ext   = TOT_W'(per_rdata);
	assign hit       = data_ok_q && (per_ext > rem_q);
	assign last      = data_ok_q && (CNT_W'(cmp_idx_q) == count_q - CNT_W'(1));
	assign found_ext = CMP_W'(cmp_idx_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			astf_pkg::S_IDLE: begin
				if (accept) begin
					state_d = astf_pkg::S_DONE;
					if (cmd.command == astf_pkg::CMD_SET_PER && idx_ok) begin
						state_d = astf_pkg::S_SETP;
					end
					if (cmd.command == astf_pkg::CMD_LOOKUP && count_q != '0 &&
					    total_q != '0) begin
						state_d = astf_pkg::S_DIV;
					end
				end
			end
			astf_pkg::S_SETP: state_d = astf_pkg::S_DONE;
			astf_pkg::S_DIV: begin
				if (bit_q == BIT_W'(astf_pkg::TICKS_W - 1)) begin
					state_d = astf_pkg::S_WALK;
				end
			end
			astf_pkg::S_WALK: begin
				if (hit || last) begin
					state_d = astf_pkg::S_DONE;
				end
			end
			astf_pkg::S_DONE: begin
				if (out_free) begin
					state_d = astf_pkg::S_IDLE;
				end
			end
			default: state_d = astf_pkg::S_IDLE;
		endcase
	end

	// Memory strobes and stall
	always_comb begin
		cmd_stall     = (state_q != astf_pkg::S_IDLE);
		ram_per_we    = 1'b0;
		ram_frm_we    = 1'b0;
		ram_addr      = addr_q;
		ram_per_wdata = per_q;
		ram_frm_wdata = cmd.frame_index;
		case (state_q)
			astf_pkg::S_IDLE: begin
				ram_addr      = idx_addr;
				ram_per_wdata = cmd.period;
				if (cmd.command == astf_pkg::CMD_APPEND) begin
					ram_addr = cnt_addr;
					if (accept && !full) begin
						ram_per_we = 1'b1;
						ram_frm_we = 1'b1;
					end
				end
				if (accept && cmd.command == astf_pkg::CMD_SET_FRM && idx_ok) begin
					ram_frm_we = 1'b1;
				end
			end
			astf_pkg::S_SETP: ram_per_we = 1'b1;
			default: ;
		endcase
	end

	astf_ram #(
		.WIDTH(astf_pkg::PERIOD_W),
		.DEPTH(MAX_STEPS)
	) u_periods (
		.clk  (clk),
		.we   (ram_per_we),
		.addr (ram_addr),
		.wdata(ram_per_wdata),
		.rdata(per_rdata)
	);

	astf_ram #(
		.WIDTH(astf_pkg::FRAME_W),
		.DEPTH(MAX_STEPS)
	) u_frames (
		.clk  (clk),
		.we   (ram_frm_we),
		.addr (ram_addr),
		.wdata(ram_frm_wdata),
		.rdata(frm_rdata)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= astf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
		end else begin
			if (accept && cmd.command == astf_pkg::CMD_CLEAR) begin
				count_q <= '0;
				total_q <= '0;
			end
			if (accept && cmd.command == astf_pkg::CMD_APPEND && !full) begin
				count_q <= count_q + CNT_W'(1);
				total_q <= total_q + TOT_W'(cmd.period);
			end
			if (state_q == astf_pkg::S_SETP) begin
				total_q <= total_q - TOT_W'(per_rdata) + TOT_W'(per_q);
			end
		end
	end

	// Working registers: remainder, walk address, pending result
	always_ff @(posedge clk) begin
		case (state_q)
			astf_pkg::S_IDLE: begin
				res_q  <= '{found_step: '0, found_frame: '0, status: cmd_status};
				addr_q <= idx_addr;
				per_q  <= cmd.period;
				rem_q  <= '0;
				quo_q  <= cmd.elapsed_ticks;
				bit_q  <= '0;
			end
			astf_pkg::S_DIV: begin
				rem_q     <= rem_div;
				quo_q     <= {quo_q[astf_pkg::TICKS_W-2:0], 1'b0};
				bit_q     <= bit_q + BIT_W'(1);
				addr_q    <= '0;
				data_ok_q <= 1'b0;
			end
			astf_pkg::S_WALK: begin
				// advance the read address; the compare index trails it by one entry
				addr_q    <= addr_q + ADDR_W'(1);
				cmp_idx_q <= addr_q;
				data_ok_q <= 1'b1;
				if (data_ok_q && !hit) begin
					rem_q <= rem_q - per_ext;
				end
				if (hit) begin
					res_q.found_step  <= found_ext[astf_pkg::IDX_W-1:0];
					res_q.found_frame <= frm_rdata;
				end
			end
			default: ;
		endcase
	end

	// Output register: load on free slot, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == astf_pkg::S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == astf_pkg::S_DONE && out_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/astf_ram.sv
`timescale 1ns / 1ps

module astf_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on strobe, register the read (old data on a same-address write)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
